// ----- design/belief_update_step_defines.svh -----
// Assertion macros for the checker file.
`ifndef BELIEF_UPDATE_STEP_DEFINES_SVH
`define BELIEF_UPDATE_STEP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BUS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("belief_update_step: same-cycle check failed");

// next-cycle implication, disabled in reset
`define BUS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("belief_update_step: next-cycle check failed");

`endif

// ----- design/bus_pkg.sv -----
`timescale 1ns / 1ps

package bus_pkg;

	localparam int SSUM_W = 42;
	localparam int WSUM_W = 26;
	localparam int SEG_W  = 36;
	localparam int DIV_W  = 43;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] OP_EXPOSURE = 2'd0;
	localparam logic [1:0] OP_SEGMENT  = 2'd1;
	localparam logic [1:0] OP_FINISH   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_INERTIA   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REBOUND   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LRATE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VAR_RATE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VAR_FLOOR = 3'd5;

	localparam logic [14:0] RST_INERTIA   = 15'd27853;
	localparam logic [14:0] RST_GAIN      = 15'd3277;
	localparam logic [14:0] RST_REBOUND   = 15'd1638;
	localparam logic [14:0] RST_LRATE     = 15'd3277;
	localparam logic [14:0] RST_VAR_RATE  = 15'd328;
	localparam logic [15:0] RST_VAR_FLOOR = 16'd1638;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [15:0] stance;
		logic [15:0]        strength;
		logic [15:0]        segment_weight;
		logic [15:0]        segment_susceptibility;
		logic [15:0]        segment_rigidity;
		logic signed [15:0] current_mean;
		logic signed [15:0] current_momentum;
		logic signed [15:0] current_core;
		logic [15:0]        current_variance;
	} bus_item_t;

	typedef struct packed {
		logic signed [15:0] new_mean;
		logic signed [15:0] new_momentum;
		logic [15:0]        new_variance;
		logic               was_updated;
	} bus_result_t;

	typedef struct packed {
		logic [14:0] inertia_factor;
		logic [14:0] influence_gain;
		logic [14:0] rebound_gain;
		logic [14:0] base_learning_rate;
		logic [14:0] variance_rate;
		logic [15:0] variance_floor;
	} bus_cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} bus_fin_stat_t;

	function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
		logic signed [15:0] r;
		if (x > 64'sd32767)
			r = 16'sh7fff;
		else if (x < -64'sd32768)
			r = 16'sh8000;
		else
			r = x[15:0];
		return r;
	endfunction

endpackage

// ----- design/belief_update_step.sv -----
`timescale 1ns / 1ps
// channel  | handshake               | payload
// item     | item_valid / item_stall | item   (bus_item_t)
// result   | result_valid / result_stall | result (bus_result_t)
// cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Exposure, segment and unused-code requests are taken whenever item_stall is low.
// A finish request runs the 43-step serial divide for the mean influence and
// eight passes through the shared multiplier, or skips both when total
// strength is zero. item_stall is high while a finish runs.
// A finished result waits in the output register while accumulation goes on;
// the next finish holds in its last step until that register frees up.
// Reset clears the sums and loads the default coefficients.

module belief_update_step (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  bus_pkg::bus_item_t                  item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output bus_pkg::bus_result_t                result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bus_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [15:0]                         cfg_data
);

	bus_pkg::bus_cfg_t                 cfg_q;
	logic signed [bus_pkg::SSUM_W-1:0] ssum_q;
	logic [bus_pkg::WSUM_W-1:0]        wsum_q;
	logic [bus_pkg::SEG_W-1:0]         susc_q, rig_q;
	logic                              result_valid_q;
	bus_pkg::bus_result_t              result_q;

	bus_pkg::bus_fin_stat_t fin_stat;
	bus_pkg::bus_result_t   fin_res;

	logic item_acc, fin_start, res_load;
	logic signed [31:0]                exp_prod;
	logic [bus_pkg::SSUM_W:0]          ssum_add;
	logic [bus_pkg::WSUM_W:0]          wsum_add;
	logic [31:0]                       susc_prod, rig_prod;
	logic [bus_pkg::SEG_W:0]           susc_add, rig_add;
	logic signed [bus_pkg::SSUM_W-1:0] ssum_nx;

	assign item_acc  = item_valid & ~item_stall;
	assign fin_start = item_acc & (item.operation == bus_pkg::OP_FINISH);
	assign res_load  = fin_stat.done & (~result_valid_q | ~result_stall);

	assign exp_prod = item.stance * $signed({1'b0, item.strength});
	assign ssum_add = {ssum_q[bus_pkg::SSUM_W-1], ssum_q} + (bus_pkg::SSUM_W + 1)'(exp_prod);
	assign wsum_add = {1'b0, wsum_q} + (bus_pkg::WSUM_W + 1)'(item.strength);
	assign susc_prod = item.segment_weight * item.segment_susceptibility;
	assign rig_prod  = item.segment_weight * item.segment_rigidity;
	assign susc_add  = {1'b0, susc_q} + (bus_pkg::SEG_W + 1)'(susc_prod);
	assign rig_add   = {1'b0, rig_q} + (bus_pkg::SEG_W + 1)'(rig_prod);

	// saturate on signed overflow of the stance sum
	always_comb begin
		if (ssum_add[bus_pkg::SSUM_W] != ssum_add[bus_pkg::SSUM_W-1])
			ssum_nx = ssum_add[bus_pkg::SSUM_W] ? {1'b1, {(bus_pkg::SSUM_W-1){1'b0}}}
			                                    : {1'b0, {(bus_pkg::SSUM_W-1){1'b1}}};
		else
			ssum_nx = ssum_add[bus_pkg::SSUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inertia_factor     <= bus_pkg::RST_INERTIA;
			cfg_q.influence_gain     <= bus_pkg::RST_GAIN;
			cfg_q.rebound_gain       <= bus_pkg::RST_REBOUND;
			cfg_q.base_learning_rate <= bus_pkg::RST_LRATE;
			cfg_q.variance_rate      <= bus_pkg::RST_VAR_RATE;
			cfg_q.variance_floor     <= bus_pkg::RST_VAR_FLOOR;
			ssum_q         <= '0;
			wsum_q         <= '0;
			susc_q         <= '0;
			rig_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					bus_pkg::REG_INERTIA:   cfg_q.inertia_factor     <= cfg_data[14:0];
					bus_pkg::REG_GAIN:      cfg_q.influence_gain     <= cfg_data[14:0];
					bus_pkg::REG_REBOUND:   cfg_q.rebound_gain       <= cfg_data[14:0];
					bus_pkg::REG_LRATE:     cfg_q.base_learning_rate <= cfg_data[14:0];
					bus_pkg::REG_VAR_RATE:  cfg_q.variance_rate      <= cfg_data[14:0];
					bus_pkg::REG_VAR_FLOOR: cfg_q.variance_floor     <= cfg_data;
					default: ;
				endcase
			end

			if (item_acc) begin
				unique case (item.operation)
					bus_pkg::OP_EXPOSURE: begin
						ssum_q <= ssum_nx;
						wsum_q <= wsum_add[bus_pkg::WSUM_W] ? '1
						                                    : wsum_add[bus_pkg::WSUM_W-1:0];
					end
					bus_pkg::OP_SEGMENT: begin
						susc_q <= susc_add[bus_pkg::SEG_W] ? '1 : susc_add[bus_pkg::SEG_W-1:0];
						rig_q  <= rig_add[bus_pkg::SEG_W] ? '1 : rig_add[bus_pkg::SEG_W-1:0];
					end
					bus_pkg::OP_FINISH: begin
						// finish unit captures the sums on this edge
						ssum_q <= '0;
						wsum_q <= '0;
						susc_q <= '0;
						rig_q  <= '0;
					end
					default: ;
				endcase
			end

			if (res_load)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load)
			result_q <= fin_res;
	end

	bus_finish u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (fin_start),
		.ack      (res_load),
		.item     (item),
		.ssum     (ssum_q),
		.wsum     (wsum_q),
		.susc_sum (susc_q),
		.rig_sum  (rig_q),
		.cfg      (cfg_q),
		.stat     (fin_stat),
		.res      (fin_res)
	);

	assign item_stall   = fin_stat.busy;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

endmodule

// ----- design/bus_finish.sv -----
`timescale 1ns / 1ps

module bus_finish (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              ack,
	input  bus_pkg::bus_item_t                item,
	input  logic signed [bus_pkg::SSUM_W-1:0] ssum,
	input  logic [bus_pkg::WSUM_W-1:0]        wsum,
	input  logic [bus_pkg::SEG_W-1:0]         susc_sum,
	input  logic [bus_pkg::SEG_W-1:0]         rig_sum,
	input  bus_pkg::bus_cfg_t                 cfg,
	output bus_pkg::bus_fin_stat_t            stat,
	output bus_pkg::bus_result_t              res
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MW, ST_NUM, ST_DIV, ST_QUO, ST_M1, ST_M2, ST_M3,
		ST_MOM, ST_M5, ST_M6, ST_MEAN, ST_VAR, ST_DONE
	} state_t;

	state_t                            state_q;
	logic [5:0]                        cnt_q;
	logic signed [15:0]                m_q, mom_q, core_q;
	logic [15:0]                       var_q;
	logic signed [bus_pkg::SSUM_W-1:0] ssum_q;
	logic [bus_pkg::WSUM_W-1:0]        wsum_q;
	logic [20:0]                       susc15_q;
	logic [bus_pkg::SEG_W-1:0]         rig_q;
	logic                              neg_q;
	logic [bus_pkg::WSUM_W-1:0]        rem_q;
	logic [bus_pkg::DIV_W-1:0]         dq_q;
	logic signed [17:0]                infl_q;
	logic signed [63:0]                prod_q, acc_q;
	bus_pkg::bus_result_t              res_q;

	logic signed [39:0] mul_a;
	logic signed [23:0] mul_b;
	logic signed [63:0] mul_p;

	logic [bus_pkg::WSUM_W:0]   trial;
	logic                       q_bit;
	logic [bus_pkg::WSUM_W-1:0] rem_nx;
	logic signed [63:0]         num, num_mag;
	logic signed [17:0]         infl_sat;
	logic signed [63:0]         mom_sum, mom_rnd, r15_full, r15_sh;
	logic signed [63:0]         mean_acc, mean_rnd, m_shift;
	logic signed [63:0]         var_diff, var_sh;
	logic signed [16:0]         m_diff;

	// shared multiplier, operands chosen by the sequencer
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MW: begin
				mul_a = $signed({14'b0, wsum_q});
				mul_b = 24'(m_q);
			end
			ST_M1: begin
				mul_a = 40'(infl_q);
				mul_b = $signed({3'b0, susc15_q});
			end
			ST_M2: begin
				mul_a = prod_q[39:0];
				mul_b = $signed({9'b0, cfg.influence_gain});
			end
			ST_M3: begin
				mul_a = 40'(mom_q);
				mul_b = $signed({9'b0, cfg.inertia_factor});
			end
			ST_MOM: begin
				mul_a = r15_sh[39:0];
				mul_b = $signed({9'b0, cfg.base_learning_rate});
			end
			ST_M5: begin
				mul_a = prod_q[39:0];
				mul_b = 24'(res_q.new_momentum);
			end
			ST_M6: begin
				mul_a = 40'(m_diff);
				mul_b = $signed({9'b0, cfg.rebound_gain});
			end
			ST_MEAN: begin
				mul_a = $signed({14'b0, wsum_q});
				mul_b = $signed({9'b0, cfg.variance_rate});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// restoring divide step: one quotient bit a cycle
	assign trial  = {rem_q, dq_q[bus_pkg::DIV_W-1]};
	assign q_bit  = (trial >= {1'b0, wsum_q});
	assign rem_nx = q_bit ? bus_pkg::WSUM_W'(trial - {1'b0, wsum_q})
	                      : trial[bus_pkg::WSUM_W-1:0];

	assign num     = 64'(ssum_q) - prod_q;
	assign num_mag = num[63] ? -num : num;

	always_comb begin
		if (!neg_q)
			infl_sat = (|dq_q[bus_pkg::DIV_W-1:17]) ? 18'sh1ffff : $signed({1'b0, dq_q[16:0]});
		else if (dq_q > 43'd131072)
			infl_sat = 18'sh20000;
		else
			infl_sat = -$signed(dq_q[17:0]);
	end

	assign mom_sum  = acc_q + (prod_q <<< 17);
	assign mom_rnd  = (mom_sum + 64'sd2147483648) >>> 32;
	assign r15_full = (64'sd1 <<< 30) - $signed({28'b0, rig_q});
	assign r15_sh   = r15_full >>> 15;
	assign m_diff   = 17'(m_q) - 17'(core_q);
	assign m_shift  = 64'(m_q) <<< 28;
	assign mean_acc = acc_q - (prod_q <<< 13);
	assign mean_rnd = (mean_acc + (64'sd1 <<< 27)) >>> 28;
	assign var_diff = $signed({36'b0, var_q, 12'b0}) - prod_q;
	assign var_sh   = var_diff >>> 12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						m_q      <= item.current_mean;
						mom_q    <= item.current_momentum;
						core_q   <= item.current_core;
						var_q    <= item.current_variance;
						ssum_q   <= ssum;
						wsum_q   <= wsum;
						susc15_q <= susc_sum[bus_pkg::SEG_W-1:15];
						rig_q    <= rig_sum;
						if (wsum == '0) begin
							// nothing seen: pass the belief through
							res_q.new_mean     <= item.current_mean;
							res_q.new_momentum <= item.current_momentum;
							res_q.new_variance <= item.current_variance;
							res_q.was_updated  <= 1'b0;
							state_q            <= ST_DONE;
						end else begin
							state_q <= ST_MW;
						end
					end
				end
				ST_MW: begin
					prod_q  <= mul_p;
					state_q <= ST_NUM;
				end
				ST_NUM: begin
					neg_q   <= num[63];
					dq_q    <= num_mag[bus_pkg::DIV_W-1:0];
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_nx;
					dq_q  <= {dq_q[bus_pkg::DIV_W-2:0], q_bit};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(bus_pkg::DIV_W - 1))
						state_q <= ST_QUO;
				end
				ST_QUO: begin
					infl_q  <= infl_sat;
					state_q <= ST_M1;
				end
				ST_M1: begin
					prod_q  <= mul_p;
					state_q <= ST_M2;
				end
				ST_M2: begin
					prod_q  <= mul_p;
					state_q <= ST_M3;
				end
				ST_M3: begin
					acc_q   <= prod_q;
					prod_q  <= mul_p;
					state_q <= ST_MOM;
				end
				ST_MOM: begin
					res_q.new_momentum <= bus_pkg::sat16(mom_rnd);
					prod_q             <= mul_p;
					state_q            <= ST_M5;
				end
				ST_M5: begin
					prod_q  <= mul_p;
					state_q <= ST_M6;
				end
				ST_M6: begin
					acc_q   <= prod_q + m_shift;
					prod_q  <= mul_p;
					state_q <= ST_MEAN;
				end
				ST_MEAN: begin
					res_q.new_mean <= bus_pkg::sat16(mean_rnd);
					prod_q         <= mul_p;
					state_q        <= ST_VAR;
				end
				ST_VAR: begin
					if (var_sh < $signed({48'b0, cfg.variance_floor}))
						res_q.new_variance <= cfg.variance_floor;
					else
						res_q.new_variance <= var_sh[15:0];
					res_q.was_updated <= 1'b1;
					state_q           <= ST_DONE;
				end
				ST_DONE: begin
					if (ack)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign res       = res_q;

endmodule

// ----- design/bus_checker.sv -----
`timescale 1ns / 1ps
`include "belief_update_step_defines.svh"

module bus_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_valid,
	input logic                 item_stall,
	input bus_pkg::bus_item_t   item,
	input logic                 result_valid,
	input logic                 result_stall,
	input bus_pkg::bus_result_t result,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);

	// a finish request always makes the block busy: item_stall goes high once it is taken
	`BUS_ASSERT_NEXT(a_finish_busy, item_valid && !item_stall && item.operation == bus_pkg::OP_FINISH, item_stall)

	// a new result only comes out of a running finish
	`BUS_ASSERT_NOW(a_result_from_finish, $rose(result_valid), $past(item_stall))

	`BUS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

	`BUS_ASSERT_NOW(a_cfg_always_ready, cfg_valid, cfg_ready)

endmodule

bind belief_update_step bus_checker u_bus_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);

// ----- verif/belief_update_step_test.sv -----
`timescale 1ns / 1ps

module belief_update_step_test;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [bus_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int IDLE_MAX       = 12;
	localparam int SETTLE_CYCLES  = 80;
	localparam int END_CYCLES     = 120;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;

	localparam longint STANCE_ACC_MAX = (64'sd1 <<< (bus_pkg::SSUM_W - 1)) - 64'sd1;
	localparam longint STANCE_ACC_MIN = -(64'sd1 <<< (bus_pkg::SSUM_W - 1));
	localparam longint WEIGHT_ACC_MAX = (64'sd1 <<< bus_pkg::WSUM_W) - 64'sd1;
	localparam longint SEG_ACC_MAX    = (64'sd1 <<< bus_pkg::SEG_W) - 64'sd1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	bus_pkg::bus_item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	bus_pkg::bus_result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bus_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	belief_update_step dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state: coefficients and running sums
	bus_pkg::bus_cfg_t coeff = '{bus_pkg::RST_INERTIA, bus_pkg::RST_GAIN,
		bus_pkg::RST_REBOUND, bus_pkg::RST_LRATE, bus_pkg::RST_VAR_RATE,
		bus_pkg::RST_VAR_FLOOR};
	longint stance_acc = 0;
	longint weight_acc = 0;
	longint susc_acc = 0;
	longint rigid_acc = 0;

	bus_pkg::bus_result_t pending_beliefs[$];
	int mismatches = 0;
	int tx_idle_max = 0;
	int rx_idle_max = 0;
	int hold_off_cycles = 0;
	int quiet_cycles = 0;

	function automatic longint clamp_to(input longint x, input longint lo, input longint hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

	function automatic void apply_reg(input logic [bus_pkg::CFG_IDX_W-1:0] idx,
		input logic [15:0] data);
		case (idx)
			bus_pkg::REG_INERTIA:   coeff.inertia_factor = data[14:0];
			bus_pkg::REG_GAIN:      coeff.influence_gain = data[14:0];
			bus_pkg::REG_REBOUND:   coeff.rebound_gain = data[14:0];
			bus_pkg::REG_LRATE:     coeff.base_learning_rate = data[14:0];
			bus_pkg::REG_VAR_RATE:  coeff.variance_rate = data[14:0];
			bus_pkg::REG_VAR_FLOOR: coeff.variance_floor = data;
			default: ;
		endcase
	endfunction

	function automatic void predict_belief(input bus_pkg::bus_item_t r);
		longint m, mom, core, var_q, w, infl, susc15, drive, carry, nm, r15, rate, acc, nmean, nv;
		bus_pkg::bus_result_t res;
		case (r.operation)
			bus_pkg::OP_EXPOSURE: begin
				stance_acc = clamp_to(stance_acc + longint'($signed(r.stance)) *
					longint'(r.strength), STANCE_ACC_MIN, STANCE_ACC_MAX);
				weight_acc = clamp_to(weight_acc + longint'(r.strength), 0, WEIGHT_ACC_MAX);
			end
			bus_pkg::OP_SEGMENT: begin
				susc_acc = clamp_to(susc_acc + longint'(r.segment_weight) *
					longint'(r.segment_susceptibility), 0, SEG_ACC_MAX);
				rigid_acc = clamp_to(rigid_acc + longint'(r.segment_weight) *
					longint'(r.segment_rigidity), 0, SEG_ACC_MAX);
			end
			bus_pkg::OP_FINISH: begin
				m = longint'($signed(r.current_mean));
				mom = longint'($signed(r.current_momentum));
				core = longint'($signed(r.current_core));
				var_q = longint'(r.current_variance);
				w = weight_acc;
				if (w == 0) begin
					res.new_mean = r.current_mean;
					res.new_momentum = r.current_momentum;
					res.new_variance = r.current_variance;
					res.was_updated = 1'b0;
				end else begin
					infl = clamp_to((stance_acc - m * w) / w, -131072, 131071);
					susc15 = susc_acc >>> 15;
					drive = infl * susc15 * longint'(coeff.influence_gain);
					carry = longint'(coeff.inertia_factor) * mom * (64'sd1 <<< 17);
					nm = clamp_to((drive + carry + (64'sd1 <<< 31)) >>> 32, -32768, 32767);
					// learning rate goes negative once rigidity passes one
					r15 = ((64'sd1 <<< 30) - rigid_acc) >>> 15;
					rate = longint'(coeff.base_learning_rate) * r15;
					acc = rate * nm - longint'(coeff.rebound_gain) * (m - core) * 8192 +
						m * (64'sd1 <<< 28);
					nmean = clamp_to((acc + (64'sd1 <<< 27)) >>> 28, -32768, 32767);
					nv = (var_q * 4096 - longint'(coeff.variance_rate) * w) >>> 12;
					if (nv < longint'(coeff.variance_floor))
						nv = longint'(coeff.variance_floor);
					res.new_mean = nmean[15:0];
					res.new_momentum = nm[15:0];
					res.new_variance = nv[15:0];
					res.was_updated = 1'b1;
				end
				pending_beliefs = {pending_beliefs, res};
				stance_acc = 0;
				weight_acc = 0;
				susc_acc = 0;
				rigid_acc = 0;
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("%0t: mismatch: %s", $time, msg);
	endtask

	task automatic check_belief(input bus_pkg::bus_result_t got);
		bus_pkg::bus_result_t want;
		if (pending_beliefs.size() == 0) begin
			report_mismatch($sformatf("result %h with no request pending", got));
			return;
		end
		want = pending_beliefs.pop_front();
		if (got.new_mean !== want.new_mean)
			report_mismatch($sformatf("new_mean got %0d want %0d",
				got.new_mean, want.new_mean));
		if (got.new_momentum !== want.new_momentum)
			report_mismatch($sformatf("new_momentum got %0d want %0d",
				got.new_momentum, want.new_momentum));
		if (got.new_variance !== want.new_variance)
			report_mismatch($sformatf("new_variance got %0d want %0d",
				got.new_variance, want.new_variance));
		if (got.was_updated !== want.was_updated)
			report_mismatch($sformatf("was_updated got %b want %b",
				got.was_updated, want.was_updated));
	endtask

	// valid stays high after acceptance; the next call or a drain decides what follows
	task automatic send_request(input bus_pkg::bus_item_t r);
		int gap;
		gap = $urandom_range(0, tx_idle_max);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= r;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		predict_belief(r);
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending_beliefs.size() != 0);
	endtask

	task automatic load_coeffs(input logic [5:0][15:0] words);
		logic [bus_pkg::CFG_IDX_W-1:0] idx;
		logic [15:0] data;
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		for (int i = int'(bus_pkg::REG_INERTIA); i <= int'(REG_SPARE_HI); i++) begin
			idx = bus_pkg::CFG_IDX_W'(i);
			if (idx <= bus_pkg::REG_VAR_FLOOR)
				data = words[idx];
			else
				data = 16'($urandom);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= data;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			apply_reg(idx, data);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic void pick_idling();
		tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
		rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
	endfunction

	function automatic bus_pkg::bus_item_t random_item(input logic [1:0] op);
		bus_pkg::bus_item_t r;
		logic [159:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		r = raw[$bits(bus_pkg::bus_item_t)-1:0];
		r.operation = op;
		case ($urandom_range(0, 7))
			0: r.strength = '0;
			1: r.strength = '1;
			2: r.strength = 16'($urandom_range(1, 4096));
			default: ;
		endcase
		// segment shares mostly in range, the rest raw bits
		if ($urandom_range(0, 4) != 0) begin
			r.segment_weight = 16'($urandom_range(0, 32768));
			r.segment_susceptibility = 16'($urandom_range(0, 32768));
			r.segment_rigidity = 16'($urandom_range(0, 32768));
		end
		if ($urandom_range(0, 9) == 0)
			r.current_mean = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		if ($urandom_range(0, 9) == 0)
			r.current_momentum = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		return r;
	endfunction

	function automatic bus_pkg::bus_item_t exposure(input logic [15:0] stance,
		input logic [15:0] strength);
		bus_pkg::bus_item_t r;
		r = random_item(bus_pkg::OP_EXPOSURE);
		r.stance = stance;
		r.strength = strength;
		return r;
	endfunction

	function automatic bus_pkg::bus_item_t segment(input logic [15:0] w, input logic [15:0] s,
		input logic [15:0] rg);
		bus_pkg::bus_item_t r;
		r = random_item(bus_pkg::OP_SEGMENT);
		r.segment_weight = w;
		r.segment_susceptibility = s;
		r.segment_rigidity = rg;
		return r;
	endfunction

	function automatic bus_pkg::bus_item_t finish(input logic [15:0] mean,
		input logic [15:0] mom, input logic [15:0] core, input logic [15:0] variance);
		bus_pkg::bus_item_t r;
		r = random_item(bus_pkg::OP_FINISH);
		r.current_mean = mean;
		r.current_momentum = mom;
		r.current_core = core;
		r.current_variance = variance;
		return r;
	endfunction

	// random exposure/segment runs, each usually closed by a finish
	task automatic run_sequences(input int budget);
		int sent, e_left, s_left;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(0, 7) == 0)
				pick_idling();
			if ($urandom_range(0, 9) == 0)
				send_request(random_item(OP_UNUSED));
			e_left = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
			s_left = $urandom_range(0, 3);
			sent += e_left + s_left;
			while (e_left + s_left > 0) begin
				if ($urandom_range(1, e_left + s_left) <= e_left) begin
					send_request(random_item(bus_pkg::OP_EXPOSURE));
					e_left--;
				end else begin
					send_request(random_item(bus_pkg::OP_SEGMENT));
					s_left--;
				end
			end
			// now and then the sums carry into the next run
			if ($urandom_range(0, 19) != 0) begin
				send_request(random_item(bus_pkg::OP_FINISH));
				sent++;
			end
		end
	endtask

	task automatic test_directed_cases();
		tx_idle_max = 3;
		rx_idle_max = 3;
		// nothing accumulated: pass-through
		send_request(finish(16'h8000, 16'h7fff, 16'h0000, 16'hffff));
		send_request(random_item(OP_UNUSED));
		send_request(finish(16'h7fff, 16'h8000, 16'h8000, 16'h0000));
		send_request(exposure(16'h7fff, 16'hffff));
		send_request(exposure(16'h8000, 16'h0001));
		send_request(segment(16'h8000, 16'h8000, 16'h8000));
		send_request(segment(16'hffff, 16'h0000, 16'hffff));
		send_request(finish(16'h8000, 16'h8000, 16'h7fff, 16'h0000));
		// exposure with zero strength still leaves total strength zero
		send_request(exposure(16'h1388, 16'h0000));
		send_request(segment(16'h03e8, 16'h4000, 16'h2000));
		send_request(finish(16'h0100, 16'h0200, 16'h0300, 16'h0400));
		// huge susceptibility drives momentum into saturation
		send_request(exposure(16'h7fff, 16'h1000));
		send_request(segment(16'hffff, 16'hffff, 16'h0000));
		send_request(segment(16'hffff, 16'hffff, 16'h0000));
		send_request(segment(16'hffff, 16'hffff, 16'h0000));
		send_request(finish(16'h8000, 16'h7fff, 16'h8000, 16'hffff));
		// rigidity above one: negative learning rate
		send_request(segment(16'h8000, 16'h1000, 16'h8000));
		send_request(segment(16'h8000, 16'h1000, 16'h8000));
		send_request(exposure(16'hc000, 16'h0001));
		send_request(finish(16'h4000, 16'h2000, 16'hc000, 16'h0800));
		drain_results();
	endtask

	task automatic test_sum_saturation();
		tx_idle_max = 0;
		rx_idle_max = 2;
		repeat (1026) send_request(exposure(16'h8000, 16'hffff));
		send_request(random_item(bus_pkg::OP_FINISH));
		repeat (20) send_request(segment(16'hffff, 16'hffff, 16'hffff));
		send_request(exposure(16'h2000, 16'h0800));
		send_request(random_item(bus_pkg::OP_FINISH));
		drain_results();
	endtask

	task automatic test_output_backpressure();
		tx_idle_max = 0;
		rx_idle_max = 0;
		// sink stops after the first result; later finishes back up into the input
		hold_off_cycles = HOLD_CYCLES;
		repeat (6) begin
			send_request(random_item(bus_pkg::OP_EXPOSURE));
			send_request(random_item(bus_pkg::OP_SEGMENT));
			send_request(random_item(bus_pkg::OP_FINISH));
		end
		drain_results();
		pick_idling();
		run_sequences(8);
		drain_results();
	endtask

	task automatic test_coefficient_settings();
		logic [5:0][15:0] words;
		words = '0;
		load_coeffs(words);
		run_sequences(12);
		words = '1;
		load_coeffs(words);
		run_sequences(12);
		repeat (2) begin
			for (int i = 0; i < 6; i++)
				words[3'(i)] = 16'($urandom);
			load_coeffs(words);
			run_sequences(12);
		end
		words[bus_pkg::REG_INERTIA] = 16'(bus_pkg::RST_INERTIA);
		words[bus_pkg::REG_GAIN] = 16'(bus_pkg::RST_GAIN);
		words[bus_pkg::REG_REBOUND] = 16'(bus_pkg::RST_REBOUND);
		words[bus_pkg::REG_LRATE] = 16'(bus_pkg::RST_LRATE);
		words[bus_pkg::REG_VAR_RATE] = 16'(bus_pkg::RST_VAR_RATE);
		words[bus_pkg::REG_VAR_FLOOR] = bus_pkg::RST_VAR_FLOOR;
		load_coeffs(words);
		run_sequences(15);
	endtask

	initial begin : result_sink
		int n;
		wait (arst_n);
		forever begin
			if (hold_off_cycles > 0) begin
				result_stall <= 1'b1;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end
			n = $urandom_range(0, rx_idle_max);
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
			check_belief(result);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
			(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_sum_saturation();
		test_output_backpressure();
		test_coefficient_settings();
		drain_results();
		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
